/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one is sampled on clk and
// switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// Coverage bounds and CRC package
// Field widths, register indexes, the configuration record and the
// byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int ORIGIN_W   = 12;
	localparam int ORIGIN_MAX = (1 << ORIGIN_W) - 1;
	localparam int CFG_DIM_W  = 13;
	localparam int PIX_W      = 8;
	localparam int OUT_W      = 13;
	localparam int CRC_W      = 32;

	localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

	typedef enum logic [1:0] {
		CFG_ORIGIN_X = 2'd0,
		CFG_ORIGIN_Y = 2'd1,
		CFG_WIDTH    = 2'd2,
		CFG_HEIGHT   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [ORIGIN_W-1:0]  origin_x;
		logic [ORIGIN_W-1:0]  origin_y;
		logic [CFG_DIM_W-1:0] width;
		logic [CFG_DIM_W-1:0] height;
	} cfg_t;

	// Reflected CRC-32, one byte, with inversion on entry and exit.
	function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
		input logic [PIX_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = ~crc ^ {{(CRC_W-PIX_W){1'b0}}, b};
		for (int i = 0; i < PIX_W; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return ~r;
	endfunction

endpackage

/* rtl/coverage_bounds_and_crc.sv */
// ----------------------------------------------------------------------------
// Coverage bounds and CRC
// Bounding box, solid flag and CRC-32 of the nonzero pixels of one glyph
// bitmap streamed in raster order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  coverage
// out       source     out_valid / out_stall box_*, has_solid, pixel_crc
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel item per cycle while in_stall is low; after its last pixel is
// accepted, a bitmap's result goes through the input and output registers.
// Per pixel: a byte CRC step plus one add and compare per box edge.
// Reset clears counts and flags; the next pixel then opens a new bitmap.
// A waiting result stalls the input only when a bitmap's last pixel needs
// the output register; other pixels keep flowing while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coverage_bounds_and_crc #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cbc_pkg::PIX_W-1:0]      coverage,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cbc_pkg::OUT_W-1:0]      box_left,
	output logic [cbc_pkg::OUT_W-1:0]      box_top,
	output logic [cbc_pkg::OUT_W-1:0]      box_width,
	output logic [cbc_pkg::OUT_W-1:0]      box_height,
	output logic                           has_solid,
	output logic [cbc_pkg::CRC_W-1:0]      pixel_crc,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  cbc_pkg::cfg_idx_t              cfg_index,
	input  logic [cbc_pkg::CFG_DIM_W-1:0]  cfg_data
);
	import cbc_pkg::*;

	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int COORD_W = $clog2(ORIGIN_MAX + MAX_DIM + 1);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		else if ({1'b0, v} > (CFG_DIM_W+1)'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		else
			return DIM_W'(v);
	endfunction

	cfg_t cfg;

	cbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;

	// bitmap state
	logic [DIM_W-1:0]   col_cnt_q, row_cnt_q;
	logic [COORD_W-1:0] min_col_q, min_row_q, max_col_end_q, max_row_end_q;
	logic [CRC_W-1:0]   crc_q;
	logic               solid_q, row_has_q;

	// result register
	logic               out_valid_q;
	logic [OUT_W-1:0]   box_left_q, box_top_q, box_width_q, box_height_q;
	logic               has_solid_q;
	logic [CRC_W-1:0]   pixel_crc_q;

	logic [DIM_W-1:0]   eff_w, eff_h, col_next, row_next;
	logic               start, nz, row_end, last, out_free, s1_fire;
	logic [COORD_W-1:0] col, row, col_end, row_end_c;
	logic [COORD_W-1:0] base_min_col, base_min_row, base_max_col, base_max_row;
	logic [COORD_W-1:0] new_min_col, new_min_row, new_max_col, new_max_row;
	logic [COORD_W-1:0] x2, y2, span_x, span_y;
	logic [CRC_W-1:0]   base_crc, new_crc;
	logic               base_solid, base_row_has, new_solid, new_row_has;

	always_comb begin
		eff_w = eff_dim(cfg.width);
		eff_h = eff_dim(cfg.height);
		start = (col_cnt_q == '0) && (row_cnt_q == '0);

		// a new bitmap starts from fresh bounds
		base_min_col = start ? (COORD_W'(cfg.origin_x) + COORD_W'(eff_w)) : min_col_q;
		base_min_row = start ? (COORD_W'(cfg.origin_y) + COORD_W'(eff_h)) : min_row_q;
		base_max_col = start ? '0 : max_col_end_q;
		base_max_row = start ? '0 : max_row_end_q;
		base_crc     = start ? '0 : crc_q;
		base_solid   = start ? 1'b0 : solid_q;
		base_row_has = start ? 1'b0 : row_has_q;

		nz      = (pix_s1 != '0);
		col     = COORD_W'(cfg.origin_x) + COORD_W'(col_cnt_q);
		col_end = col + COORD_W'(1);

		new_min_col = (nz && (col < base_min_col)) ? col : base_min_col;
		new_max_col = (nz && (col_end > base_max_col)) ? col_end : base_max_col;
		new_crc     = nz ? crc32_byte(base_crc, pix_s1) : base_crc;
		new_solid   = base_solid | (pix_s1 == PIX_FULL);
		new_row_has = base_row_has | nz;

		col_next  = col_cnt_q + DIM_W'(1);
		row_end   = (col_next >= eff_w);
		row       = COORD_W'(cfg.origin_y) + COORD_W'(row_cnt_q);
		row_end_c = row + COORD_W'(1);

		new_min_row = (row_end && new_row_has && (row < base_min_row)) ? row : base_min_row;
		new_max_row = (row_end && new_row_has && (row_end_c > base_max_row)) ?
			row_end_c : base_max_row;

		row_next = row_cnt_q + DIM_W'(1);
		last     = row_end && (row_next >= eff_h);

		// clamp far edges to the near edges
		x2     = (new_max_col < new_min_col) ? new_min_col : new_max_col;
		y2     = (new_max_row < new_min_row) ? new_min_row : new_max_row;
		span_x = x2 - new_min_col;
		span_y = y2 - new_min_row;

		out_free = !out_valid_q || !out_stall;
		s1_fire  = valid_s1 && (!last || out_free);
	end

	// hold the input only when the last pixel waits for the result slot
	assign in_stall = valid_s1 && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pix_s1 <= coverage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q     <= '0;
			row_cnt_q     <= '0;
			min_col_q     <= COORD_W'(1);
			min_row_q     <= COORD_W'(1);
			max_col_end_q <= '0;
			max_row_end_q <= '0;
			crc_q         <= '0;
			solid_q       <= 1'b0;
			row_has_q     <= 1'b0;
		end else if (s1_fire) begin
			min_col_q     <= new_min_col;
			min_row_q     <= new_min_row;
			max_col_end_q <= new_max_col;
			max_row_end_q <= new_max_row;
			crc_q         <= new_crc;
			solid_q       <= new_solid;
			row_has_q     <= row_end ? 1'b0 : new_row_has;
			col_cnt_q     <= row_end ? '0 : col_next;
			if (row_end) begin
				row_cnt_q <= last ? '0 : row_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last) begin
			box_left_q   <= new_min_col[OUT_W-1:0];
			box_top_q    <= new_min_row[OUT_W-1:0];
			box_width_q  <= span_x[OUT_W-1:0];
			box_height_q <= span_y[OUT_W-1:0];
			has_solid_q  <= new_solid;
			pixel_crc_q  <= new_crc;
		end
	end

	assign out_valid  = out_valid_q;
	assign box_left   = box_left_q;
	assign box_top    = box_top_q;
	assign box_width  = box_width_q;
	assign box_height = box_height_q;
	assign has_solid  = has_solid_q;
	assign pixel_crc  = pixel_crc_q;

	`ASSERT_NEVER(a_stall_needs_item, in_stall && !valid_s1, "stall with empty input register")
	`ASSERT_CLK(a_last_gives_result, (s1_fire && last) |=> out_valid, "last pixel gave no result")
	`ASSERT_CLK(a_counts_clear, (s1_fire && last) |=> (col_cnt_q == '0 && row_cnt_q == '0), "counts not cleared after bitmap")
	`ASSERT_CLK(a_box_empty_both, out_valid |-> ((box_width == '0) == (box_height == '0)), "box empty in one axis only")

endmodule

/* rtl/cbc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds origin and bitmap dimensions; one write per cycle, always ready.
// ----------------------------------------------------------------------------
module cbc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  cbc_pkg::cfg_idx_t              cfg_index,
	input  logic [cbc_pkg::CFG_DIM_W-1:0]  cfg_data,
	output cbc_pkg::cfg_t                  cfg
);
	import cbc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.width    <= CFG_DIM_W'(1);
			cfg_q.height   <= CFG_DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data[ORIGIN_W-1:0];
				CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data[ORIGIN_W-1:0];
				CFG_WIDTH:    cfg_q.width    <= cfg_data;
				CFG_HEIGHT:   cfg_q.height   <= cfg_data;
				default:      ;
			endcase
		end
	end

endmodule
